// ===== design/dtrm_pkg.sv =====
// Shared types and codes for the direction to rotation matrix block.
// Holds the status codes, the result field width and the sideband flags
// struct. Depends on nothing.
package dtrm_pkg;

    // Width of every matrix entry on the result ports.
    localparam int OUT_W = 16;

    // Status codes reported with each result item.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_AXIS = 2'd2;

    // Flags that travel alongside the square root cells.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic zero_vec;
        logic on_axis;
    } dtrm_side_t;

endpackage

// ===== design/dtrm_cell.sv =====
// One bit step of the ratio square root: decides one bit of
// q = round(ONE * sqrt(num / den)) and registers the running terms.
// Depends on nothing; instantiated in rows by the top level.
module dtrm_cell #(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14,
    parameter int BIT       = 0
) (
    input  logic                                      clk,
    input  logic [2*FRAC_BITS+2+2*IN_WIDTH-1:0]       num_k,
    input  logic [2*IN_WIDTH-1:0]                     den,
    input  logic [2*FRAC_BITS+2+2*IN_WIDTH-1:0]       acc_a,
    input  logic [FRAC_BITS+1+2*IN_WIDTH-1:0]         acc_b,
    input  logic [FRAC_BITS:0]                        q,
    output logic [2*FRAC_BITS+2+2*IN_WIDTH-1:0]       num_k_out,
    output logic [2*IN_WIDTH-1:0]                     den_out,
    output logic [2*FRAC_BITS+2+2*IN_WIDTH-1:0]       acc_a_out,
    output logic [FRAC_BITS+1+2*IN_WIDTH-1:0]         acc_b_out,
    output logic [FRAC_BITS:0]                        q_out
);

    localparam int SQW = 2 * IN_WIDTH;
    localparam int QW  = FRAC_BITS + 1;
    localparam int AW  = 2 * FRAC_BITS + 2 + SQW;
    localparam int BW  = QW + SQW;

    logic [AW-1:0] a_try;
    logic [BW-1:0] b_try;
    logic [AW+1:0] lhs;
    logic          fit;

    logic [AW-1:0]  num_k_reg;
    logic [SQW-1:0] den_reg;
    logic [AW-1:0]  acc_a_reg;
    logic [BW-1:0]  acc_b_reg;
    logic [QW-1:0]  q_reg;

    // With acc_a = q*q*den and acc_b = q*den, setting bit BIT of q moves
    // both by shifts and adds only. The test is (2q-1)^2 * den <= num_k.
    always_comb
    begin
        a_try = acc_a + (AW'(acc_b) << (BIT + 1)) + (AW'(den) << (2 * BIT));
        b_try = acc_b + (BW'(den) << BIT);
        lhs   = {a_try, 2'b00} - (AW + 2)'({b_try, 2'b00}) + (AW + 2)'(den);
        fit   = (lhs <= {2'b00, num_k});
    end

    // Take the bit when it fits, otherwise pass the terms on unchanged.
    always_ff @(posedge clk)
    begin
        num_k_reg <= num_k;
        den_reg   <= den;
        if (fit)
        begin
            acc_a_reg <= a_try;
            acc_b_reg <= b_try;
            q_reg     <= q | (QW'(1) << BIT);
        end
        else
        begin
            acc_a_reg <= acc_a;
            acc_b_reg <= acc_b;
            q_reg     <= q;
        end
    end

    assign num_k_out = num_k_reg;
    assign den_out   = den_reg;
    assign acc_a_out = acc_a_reg;
    assign acc_b_out = acc_b_reg;
    assign q_out     = q_reg;

endmodule

// ===== design/dtrm_mix.sv =====
// Final stages: applies signs and special cases to the four angle terms,
// forms the rounded products and registers the matrix and status.
// Depends on dtrm_pkg.
module dtrm_mix
    import dtrm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                    clk,
    input  logic [FRAC_BITS:0]      q_cy,
    input  logic [FRAC_BITS:0]      q_sy,
    input  logic [FRAC_BITS:0]      q_ca,
    input  logic [FRAC_BITS:0]      q_sa,
    input  dtrm_side_t              side,
    output logic signed [OUT_W-1:0] m00,
    output logic signed [OUT_W-1:0] m01,
    output logic signed [OUT_W-1:0] m02,
    output logic signed [OUT_W-1:0] m10,
    output logic signed [OUT_W-1:0] m11,
    output logic signed [OUT_W-1:0] m12,
    output logic signed [OUT_W-1:0] m20,
    output logic signed [OUT_W-1:0] m21,
    output logic signed [OUT_W-1:0] m22,
    output logic [1:0]              status
);

    localparam int QW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 2;
    localparam int PW = 2 * QW;
    localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    // Term magnitudes and signs, first stage.
    logic [QW-1:0] ca_reg, sa_reg, cy_reg, sy_reg;
    logic          ca_neg_reg, sa_neg_reg, cy_neg_reg;
    logic [1:0]    st1_reg;
    logic          no_az;

    // Products, second stage.
    logic [PW-1:0] p00_reg, p02_reg, p10_reg, p12_reg;
    logic [QW-1:0] ca2_reg, sa2_reg, cy2_reg, sy2_reg;
    logic          ca_neg2_reg, sa_neg2_reg, cy_neg2_reg;
    logic [1:0]    st2_reg;

    // Rounded products, third stage inputs.
    logic [PW-1:0] r00, r02, r10, r12;

    // Signs a magnitude and wraps it onto the result width.
    function automatic logic [OUT_W-1:0] to_out(input logic [QW-1:0] mag, input logic neg);
        logic signed [TW-1:0] v;
        logic signed [31:0]   w;
        v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    // A zero vector takes the identity; on the z axis the azimuth is fixed.
    assign no_az = side.zero_vec | side.on_axis;

    always_ff @(posedge clk)
    begin
        ca_reg     <= no_az ? ONE : q_ca;
        sa_reg     <= no_az ? '0 : q_sa;
        cy_reg     <= side.zero_vec ? ONE : q_cy;
        sy_reg     <= side.zero_vec ? '0 : q_sy;
        ca_neg_reg <= side.neg_x & ~no_az;
        sa_neg_reg <= side.neg_y & ~no_az;
        cy_neg_reg <= side.neg_z & ~side.zero_vec;
        st1_reg    <= side.zero_vec ? ST_ZERO : (side.on_axis ? ST_AXIS : ST_OK);
    end

    // The four products of two terms.
    always_ff @(posedge clk)
    begin
        p00_reg     <= PW'(ca_reg) * PW'(cy_reg);
        p02_reg     <= PW'(ca_reg) * PW'(sy_reg);
        p10_reg     <= PW'(sa_reg) * PW'(cy_reg);
        p12_reg     <= PW'(sa_reg) * PW'(sy_reg);
        ca2_reg     <= ca_reg;
        sa2_reg     <= sa_reg;
        cy2_reg     <= cy_reg;
        sy2_reg     <= sy_reg;
        ca_neg2_reg <= ca_neg_reg;
        sa_neg2_reg <= sa_neg_reg;
        cy_neg2_reg <= cy_neg_reg;
        st2_reg     <= st1_reg;
    end

    // Rounding to the fraction width, ties away from zero on the magnitude.
    always_comb
    begin
        r00 = (p00_reg + HALF) >> FRAC_BITS;
        r02 = (p02_reg + HALF) >> FRAC_BITS;
        r10 = (p10_reg + HALF) >> FRAC_BITS;
        r12 = (p12_reg + HALF) >> FRAC_BITS;
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        m00    <= to_out(r00[QW-1:0], ca_neg2_reg ^ cy_neg2_reg);
        m01    <= to_out(sa2_reg, ~sa_neg2_reg);
        m02    <= to_out(r02[QW-1:0], ca_neg2_reg);
        m10    <= to_out(r10[QW-1:0], sa_neg2_reg ^ cy_neg2_reg);
        m11    <= to_out(ca2_reg, ca_neg2_reg);
        m12    <= to_out(r12[QW-1:0], sa_neg2_reg);
        m20    <= to_out(sy2_reg, 1'b1);
        m21    <= '0;
        m22    <= to_out(cy2_reg, cy_neg2_reg);
        status <= st2_reg;
    end

endmodule

// ===== design/direction_to_rotation_matrix.sv =====
// Top level of the direction to rotation matrix block.
// Depends on dtrm_pkg, dtrm_cell and dtrm_mix.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------
//  input    | start, busy      | dir_x, dir_y, dir_z
//  result   | done (strobe)    | m00 .. m22, status
//
// One item is taken in every cycle; busy is never raised.
// Each item passes through the squares and sums registers, one cell per
// result bit of the square root rows, and the sign handling, product and
// result registers of dtrm_mix.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so done marks each result for one cycle.
module direction_to_rotation_matrix
    import dtrm_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [IN_WIDTH-1:0] dir_x,
    input  logic signed [IN_WIDTH-1:0] dir_y,
    input  logic signed [IN_WIDTH-1:0] dir_z,
    output logic                       done,
    output logic signed [OUT_W-1:0]    m00,
    output logic signed [OUT_W-1:0]    m01,
    output logic signed [OUT_W-1:0]    m02,
    output logic signed [OUT_W-1:0]    m10,
    output logic signed [OUT_W-1:0]    m11,
    output logic signed [OUT_W-1:0]    m12,
    output logic signed [OUT_W-1:0]    m20,
    output logic signed [OUT_W-1:0]    m21,
    output logic signed [OUT_W-1:0]    m22,
    output logic [1:0]                 status
);

    localparam int SQW   = 2 * IN_WIDTH;
    localparam int QW    = FRAC_BITS + 1;
    localparam int AW    = 2 * FRAC_BITS + 2 + SQW;
    localparam int BW    = QW + SQW;
    localparam int LAT   = QW + 5;
    localparam int LANES = 4;

    logic                  accept;
    logic signed [SQW-1:0] sx, sy, sz;

    logic [SQW-1:0] x2_reg, y2_reg, z2_reg;
    logic [SQW-1:0] x2b_reg, y2b_reg, z2b_reg, rho2_reg, r2_reg;
    logic [SQW-1:0] rho2_next, r2_next;
    dtrm_side_t     side1_reg, side2_reg;
    dtrm_side_t     side_pipe_reg [QW];
    logic [LAT-1:0] vld_reg;

    // Cell row connections: index 0 feeds the first cell of each row.
    logic [AW-1:0]  row_k [LANES][QW+1];
    logic [SQW-1:0] row_d [LANES][QW+1];
    logic [AW-1:0]  row_a [LANES][QW+1];
    logic [BW-1:0]  row_b [LANES][QW+1];
    logic [QW-1:0]  row_q [LANES][QW+1];
    logic [SQW-1:0] lane_num [LANES];
    logic [SQW-1:0] lane_den [LANES];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign done   = vld_reg[LAT-1];

    // Valid bits follow each item down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // Squares of the three components.
    assign sx = SQW'(dir_x);
    assign sy = SQW'(dir_y);
    assign sz = SQW'(dir_z);

    always_ff @(posedge clk)
    begin
        x2_reg          <= sx * sx;
        y2_reg          <= sy * sy;
        z2_reg          <= sz * sz;
        side1_reg.neg_x <= dir_x[IN_WIDTH-1];
        side1_reg.neg_y <= dir_y[IN_WIDTH-1];
        side1_reg.neg_z <= dir_z[IN_WIDTH-1];
        side1_reg.zero_vec <= 1'b0;
        side1_reg.on_axis  <= 1'b0;
    end

    // Sums of squares and the special case flags.
    assign rho2_next = x2_reg + y2_reg;
    assign r2_next   = rho2_next + z2_reg;

    always_ff @(posedge clk)
    begin
        x2b_reg            <= x2_reg;
        y2b_reg            <= y2_reg;
        z2b_reg            <= z2_reg;
        rho2_reg           <= rho2_next;
        r2_reg             <= r2_next;
        side2_reg.neg_x    <= side1_reg.neg_x;
        side2_reg.neg_y    <= side1_reg.neg_y;
        side2_reg.neg_z    <= side1_reg.neg_z;
        side2_reg.zero_vec <= (r2_next == '0);
        side2_reg.on_axis  <= (rho2_next == '0);
    end

    // Flags keep pace with the cell rows.
    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= side2_reg;
        for (int i = 1; i < QW; i++)
        begin
            side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    // Rows: cos_ay, sin_ay, cos_az, sin_az.
    assign lane_num[0] = z2b_reg;
    assign lane_den[0] = r2_reg;
    assign lane_num[1] = rho2_reg;
    assign lane_den[1] = r2_reg;
    assign lane_num[2] = x2b_reg;
    assign lane_den[2] = rho2_reg;
    assign lane_num[3] = y2b_reg;
    assign lane_den[3] = rho2_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign row_k[l][0] = {lane_num[l], (2 * FRAC_BITS + 2)'(0)};
        assign row_d[l][0] = lane_den[l];
        assign row_a[l][0] = '0;
        assign row_b[l][0] = '0;
        assign row_q[l][0] = '0;

        for (genvar i = 0; i < QW; i++)
        begin : g_cell
            dtrm_cell #(
                .IN_WIDTH  (IN_WIDTH),
                .FRAC_BITS (FRAC_BITS),
                .BIT       (FRAC_BITS - i)
            ) u_cell (
                .clk       (clk),
                .num_k     (row_k[l][i]),
                .den       (row_d[l][i]),
                .acc_a     (row_a[l][i]),
                .acc_b     (row_b[l][i]),
                .q         (row_q[l][i]),
                .num_k_out (row_k[l][i+1]),
                .den_out   (row_d[l][i+1]),
                .acc_a_out (row_a[l][i+1]),
                .acc_b_out (row_b[l][i+1]),
                .q_out     (row_q[l][i+1])
            );
        end
    end

    // Signs, products and result registers.
    dtrm_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk    (clk),
        .q_cy   (row_q[0][QW]),
        .q_sy   (row_q[1][QW]),
        .q_ca   (row_q[2][QW]),
        .q_sa   (row_q[3][QW]),
        .side   (side_pipe_reg[QW-1]),
        .m00    (m00),
        .m01    (m01),
        .m02    (m02),
        .m10    (m10),
        .m11    (m11),
        .m12    (m12),
        .m20    (m20),
        .m21    (m21),
        .m22    (m22),
        .status (status)
    );

endmodule
